FILE: design/vlmf_pkg.sv
// shared constants and codes of the variable-length message fifo
// no dependencies
package vlmf_pkg;

   localparam int QUEUE_BYTES_DEF   = 4096;
   localparam int MAX_MSGS_DEF      = 256;
   localparam int MAX_PRODUCERS_DEF = 32;

   localparam int TYPE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int MLEN_W   = 16;
   localparam int PIDX_W   = 5;
   localparam int OLEN_W   = 13;
   localparam int PCOUNT_W = 6;

   localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(1);

   typedef enum logic [TYPE_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FINISH = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_CLOSED    = 3'd4,
      ST_TOO_LONG  = 3'd5,
      ST_DROPPED   = 3'd6,
      ST_UNUSED    = 3'd7
   } status_type;

endpackage

FILE: design/vlmf_if.sv
// channel interfaces of the variable-length message fifo: request, response, csr write
// depends on vlmf_pkg
interface vlmf_req_if import vlmf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [BYTE_W-1:0] data_in;
   logic              first_of_msg;
   logic [MLEN_W-1:0] msg_length;
   logic [MLEN_W-1:0] reader_limit;
   logic [PIDX_W-1:0] producer_index;

   modport source (output valid, req_type, data_in, first_of_msg, msg_length,
                   reader_limit, producer_index, input ready);
   modport sink   (input valid, req_type, data_in, first_of_msg, msg_length,
                   reader_limit, producer_index, output ready);
endinterface

interface vlmf_rsp_if import vlmf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [BYTE_W-1:0] data_out;
   logic              last_byte;
   logic [OLEN_W-1:0] head_length;
   logic [OLEN_W-1:0] free_bytes;
   logic              drained;

   modport source (output valid, status, data_out, last_byte, head_length, free_bytes,
                   drained, input ready);
   modport sink   (input valid, status, data_out, last_byte, head_length, free_bytes,
                   drained, output ready);
endinterface

interface vlmf_csr_if import vlmf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PCOUNT_W-1:0] producer_count;

   modport source (output valid, producer_count, input ready);
   modport sink   (input valid, producer_count, output ready);
endinterface

FILE: design/vlmf_byte_ram.sv
// byte ring storage, one write and one registered read per cycle
// depends on vlmf_pkg
module vlmf_byte_ram import vlmf_pkg::*; #(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_BYTES)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]              wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(QUEUE_BYTES)-1:0] rd_addr,
   output logic [BYTE_W-1:0]              rd_data
);

   logic [BYTE_W-1:0] byte_mem [QUEUE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= byte_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/vlmf_desc_ram.sv
// descriptor storage {length, start}, one write and one registered read per cycle
// depends on vlmf_pkg
module vlmf_desc_ram import vlmf_pkg::*; #(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
   parameter int MAX_MSGS    = MAX_MSGS_DEF
) (
   input  logic                                                     clock,
   input  logic                                                     wr_en,
   input  logic [$clog2(MAX_MSGS)-1:0]                              wr_addr,
   input  logic [$clog2(QUEUE_BYTES+1)+$clog2(QUEUE_BYTES)-1:0]     wr_data,
   input  logic                                                     rd_en,
   input  logic [$clog2(MAX_MSGS)-1:0]                              rd_addr,
   output logic [$clog2(QUEUE_BYTES+1)+$clog2(QUEUE_BYTES)-1:0]     rd_data
);

   localparam int DESC_W = $clog2(QUEUE_BYTES+1) + $clog2(QUEUE_BYTES);

   logic [DESC_W-1:0] desc_mem [MAX_MSGS];
   logic [DESC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= desc_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/variable_length_message_fifo_unit.sv
// top level of the variable-length message fifo: sequencer, pointers and counters
// depends on vlmf_pkg, vlmf_if, vlmf_byte_ram, vlmf_desc_ram
//
//   channel  | dir | handshake    | transaction
//   req_bus  | in  | valid/ready  | add byte, remove byte, producer finished, nop
//   rsp_bus  | out | valid/ready  | one status/data result per request
//   csr_bus  | in  | valid/ready  | producer_count write, always ready
//
// a request passes through acceptance with the descriptor ram read, execute (state update, byte
// ram write or read), then byte ram data into the response register. the response becomes
// valid as the sequencer leaves its last step; ready returns in that same cycle, so the
// next request is accepted while a response still waits. a stalled response holds the
// sequencer in its last step. synchronous reset clears pointers, counters and the
// finished map; both rams start undefined and need no clearing pass.
module variable_length_message_fifo_unit import vlmf_pkg::*; #(
   parameter int QUEUE_BYTES   = QUEUE_BYTES_DEF,
   parameter int MAX_MSGS      = MAX_MSGS_DEF,
   parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vlmf_req_if.sink    req_bus,
   vlmf_rsp_if.source  rsp_bus,
   vlmf_csr_if.sink    csr_bus
);

   localparam int POS_W  = $clog2(QUEUE_BYTES);
   localparam int LEN_W  = $clog2(QUEUE_BYTES+1);
   localparam int DESC_W = LEN_W + POS_W;
   localparam int IDX_W  = $clog2(MAX_MSGS);
   localparam int CNT_W  = $clog2(MAX_MSGS+1);
   localparam int CMP_W  = (LEN_W > MLEN_W) ? LEN_W : MLEN_W;
   localparam int PID_W  = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
   localparam int FC_W   = $clog2(MAX_PRODUCERS+1);
   localparam int CW     = (FC_W > PCOUNT_W) ? FC_W : PCOUNT_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [BYTE_W-1:0] data_in;
      logic              first_of_msg;
      logic [MLEN_W-1:0] msg_length;
      logic [MLEN_W-1:0] reader_limit;
      logic [PIDX_W-1:0] producer_index;
   } req_hold_type;

   state_type               state_ff, state_in;
   req_hold_type            req_ff;
   logic [IDX_W-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]        wpos_ff, wpos_in;
   logic [LEN_W-1:0]        free_ff, free_in;
   logic [LEN_W-1:0]        remain_ff, remain_in;
   logic [LEN_W-1:0]        offset_ff, offset_in;
   logic [MAX_PRODUCERS-1:0] map_ff, map_in;
   logic [FC_W-1:0]         fin_cnt_ff, fin_cnt_in;
   logic [PCOUNT_W-1:0]     producer_count_ff;

   status_type              res_status_ff, res_status_in;
   logic [OLEN_W-1:0]       res_hlen_ff, res_hlen_in;
   logic                    res_last_ff, res_last_in;
   logic                    res_rd_ff, res_rd_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff;
   logic [BYTE_W-1:0]       rsp_data_ff;
   logic                    rsp_last_ff;
   logic [OLEN_W-1:0]       rsp_hlen_ff;
   logic [OLEN_W-1:0]       rsp_free_ff;
   logic                    rsp_drained_ff;

   logic                    req_take;
   logic                    rsp_load;
   logic                    closed;
   logic                    desc_we, byte_we, byte_re;
   logic [DESC_W-1:0]       desc_wdata, desc_rdata;
   logic [BYTE_W-1:0]       byte_rdata;
   logic [POS_W-1:0]        rd_pos;
   logic [POS_W:0]          pos_sum;
   logic [LEN_W-1:0]        head_len, off_nx;
   logic [POS_W-1:0]        head_start;
   logic [LEN_W-1:0]        add_len;
   logic                    bad_len, no_room;
   logic [PID_W-1:0]        pid_sel;
   logic                    pid_ok;
   req_code_type            op;

   vlmf_desc_ram #(.QUEUE_BYTES(QUEUE_BYTES), .MAX_MSGS(MAX_MSGS)) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (tail_ff),
      .wr_data (desc_wdata),
      .rd_en   (req_take),
      .rd_addr (head_ff),
      .rd_data (desc_rdata)
   );

   vlmf_byte_ram #(.QUEUE_BYTES(QUEUE_BYTES)) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (wpos_ff),
      .wr_data (req_ff.data_in),
      .rd_en   (byte_re),
      .rd_addr (rd_pos),
      .rd_data (byte_rdata)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_load      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign closed     = CW'(fin_cnt_ff) >= CW'(producer_count_ff);
   assign op         = req_code_type'(req_ff.req_type);
   assign head_len   = desc_rdata[DESC_W-1:POS_W];
   assign head_start = desc_rdata[POS_W-1:0];
   assign add_len    = LEN_W'(req_ff.msg_length);
   assign desc_wdata = {add_len, wpos_ff};
   assign pos_sum    = (POS_W+1)'(head_start) + (POS_W+1)'(offset_ff);
   assign rd_pos     = (pos_sum >= (POS_W+1)'(QUEUE_BYTES)) ?
                       POS_W'(pos_sum - (POS_W+1)'(QUEUE_BYTES)) : POS_W'(pos_sum);
   assign off_nx     = offset_ff + LEN_W'(1);
   assign bad_len    = (req_ff.msg_length == '0) ||
                       (CMP_W'(req_ff.msg_length) > CMP_W'(QUEUE_BYTES));
   assign no_room    = (CMP_W'(req_ff.msg_length) > CMP_W'(free_ff)) ||
                       (count_ff == CNT_W'(MAX_MSGS));
   assign pid_sel    = PID_W'(req_ff.producer_index);
   assign pid_ok     = 32'(req_ff.producer_index) < MAX_PRODUCERS;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      wpos_in       = wpos_ff;
      free_in       = free_ff;
      remain_in     = remain_ff;
      offset_in     = offset_ff;
      map_in        = map_ff;
      fin_cnt_in    = fin_cnt_ff;
      res_status_in = res_status_ff;
      res_hlen_in   = res_hlen_ff;
      res_last_in   = res_last_ff;
      res_rd_in     = res_rd_ff;
      desc_we       = 1'b0;
      byte_we       = 1'b0;
      byte_re       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_DONE;
            res_status_in = ST_OK;
            res_hlen_in   = '0;
            res_last_in   = 1'b0;
            res_rd_in     = 1'b0;
            unique case (op)
               REQ_ADD: begin
                  if (req_ff.first_of_msg) begin
                     if (bad_len) begin
                        res_status_in = ST_BAD_LEN;
                        remain_in     = '0;
                     end else if (closed) begin
                        res_status_in = ST_CLOSED;
                        remain_in     = '0;
                     end else if (no_room) begin
                        res_status_in = ST_FULL;
                        remain_in     = '0;
                     end else begin
                        desc_we   = 1'b1;
                        byte_we   = 1'b1;
                        tail_in   = (tail_ff == IDX_W'(MAX_MSGS - 1)) ? '0 : tail_ff + IDX_W'(1);
                        count_in  = count_ff + CNT_W'(1);
                        free_in   = free_ff - add_len;
                        wpos_in   = (wpos_ff == POS_W'(QUEUE_BYTES - 1)) ?
                                    '0 : wpos_ff + POS_W'(1);
                        remain_in = add_len - LEN_W'(1);
                     end
                  end else if (remain_ff != '0) begin
                     byte_we   = 1'b1;
                     wpos_in   = (wpos_ff == POS_W'(QUEUE_BYTES - 1)) ? '0 : wpos_ff + POS_W'(1);
                     remain_in = remain_ff - LEN_W'(1);
                  end else begin
                     res_status_in = ST_DROPPED;
                  end
               end
               REQ_REMOVE: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     res_hlen_in = OLEN_W'(head_len);
                     if ((offset_ff == '0) && (CMP_W'(head_len) > CMP_W'(req_ff.reader_limit)))
                     begin
                        res_status_in = ST_TOO_LONG;
                        free_in       = free_ff + head_len;
                        head_in       = (head_ff == IDX_W'(MAX_MSGS - 1)) ?
                                        '0 : head_ff + IDX_W'(1);
                        count_in      = count_ff - CNT_W'(1);
                        offset_in     = '0;
                     end else begin
                        byte_re   = 1'b1;
                        res_rd_in = 1'b1;
                        offset_in = off_nx;
                        if (off_nx >= head_len) begin
                           res_last_in = 1'b1;
                           free_in     = free_ff + head_len;
                           head_in     = (head_ff == IDX_W'(MAX_MSGS - 1)) ?
                                         '0 : head_ff + IDX_W'(1);
                           count_in    = count_ff - CNT_W'(1);
                           offset_in   = '0;
                        end
                     end
                  end
               end
               REQ_FINISH: begin
                  if (pid_ok && !map_ff[pid_sel]) begin
                     map_in[pid_sel] = 1'b1;
                     fin_cnt_in      = fin_cnt_ff + FC_W'(1);
                  end
               end
               REQ_NOP: begin
               end
               default: begin
               end
            endcase
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         head_ff           <= '0;
         tail_ff           <= '0;
         count_ff          <= '0;
         wpos_ff           <= '0;
         free_ff           <= LEN_W'(QUEUE_BYTES);
         remain_ff         <= '0;
         offset_ff         <= '0;
         map_ff            <= '0;
         fin_cnt_ff        <= '0;
         producer_count_ff <= PCOUNT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         wpos_ff      <= wpos_in;
         free_ff      <= free_in;
         remain_ff    <= remain_in;
         offset_ff    <= offset_in;
         map_ff       <= map_in;
         fin_cnt_ff   <= fin_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            producer_count_ff <= csr_bus.producer_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.req_type       <= req_bus.req_type;
         req_ff.data_in        <= req_bus.data_in;
         req_ff.first_of_msg   <= req_bus.first_of_msg;
         req_ff.msg_length     <= req_bus.msg_length;
         req_ff.reader_limit   <= req_bus.reader_limit;
         req_ff.producer_index <= req_bus.producer_index;
      end
      res_status_ff <= res_status_in;
      res_hlen_ff   <= res_hlen_in;
      res_last_ff   <= res_last_in;
      res_rd_ff     <= res_rd_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_data_ff    <= res_rd_ff ? byte_rdata : '0;
         rsp_last_ff    <= res_last_ff;
         rsp_hlen_ff    <= res_hlen_ff;
         rsp_free_ff    <= OLEN_W'(free_ff);
         rsp_drained_ff <= (count_ff == '0) && closed;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.data_out    = rsp_data_ff;
   assign rsp_bus.last_byte   = rsp_last_ff;
   assign rsp_bus.head_length = rsp_hlen_ff;
   assign rsp_bus.free_bytes  = rsp_free_ff;
   assign rsp_bus.drained     = rsp_drained_ff;

endmodule
